### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that are active in simulation and empty for
// synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// The property must hold at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

### hw/rtl/hssq_pkg.sv
// ---------------------------------------------------------------------------
// hssq_pkg
// Shared types, codes and the half-step coil table for the move sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hssq_pkg;

  localparam int BUTTON_W = 6;
  localparam int COIL_W   = 4;
  localparam int STEPS_W  = 16;
  localparam int PHASE_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL    = 2'd2;

  localparam logic [STEPS_W-1:0] QUARTER_RESET = 16'd1024;
  localparam logic [STEPS_W-1:0] HALF_RESET    = 16'd2048;
  localparam logic [STEPS_W-1:0] FULL_RESET    = 16'd4096;

  typedef enum logic [1:0] {
    MOVE_QUARTER = 2'd0,
    MOVE_HALF    = 2'd1,
    MOVE_FULL    = 2'd2
  } move_size_t;

  // One result beat.
  typedef struct packed {
    logic [COIL_W-1:0] coil_pattern;
    logic              moving;
  } result_t;

  // Sequencer status seen by the top level checks.
  typedef struct packed {
    logic started;
    logic busy;
  } core_status_t;

  // Eight-phase half-step table: A, AB, B, BC, C, CD, D, DA.
  function automatic logic [COIL_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

### hw/rtl/stepper_half_step_move_sequencer.sv
// ---------------------------------------------------------------------------
// stepper_half_step_move_sequencer
// Half-step stepper sequencer that runs quarter, half and full turn moves.
// ---------------------------------------------------------------------------
//
//   channel | signals                          | direction
//   --------+----------------------------------+-----------
//   in      | in_valid, in_stall, buttons      | tick in
//   out     | out_valid, out_stall,            | result out
//           | coil_pattern, moving             |
//   cfg     | cfg_we, cfg_index, cfg_data      | write only
//
// Every input beat is one tick and yields exactly one result beat. A tick is
// taken in any cycle in which the skid entry of the output buffer is free, so
// the block sustains one beat per clock while out_stall is low; the only loop
// is the update of the move state and phase index. A tick's result goes to
// the output register, or to the skid entry while the consumer stalls. Reset
// is synchronous, with the step counts back at 1024, 2048 and 4096. When the
// consumer stalls, one more tick fills the skid entry and in_stall rises.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stepper_half_step_move_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration writes.
  input  logic                               cfg_we,
  input  logic [hssq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hssq_pkg::STEPS_W-1:0]       cfg_data,
  // Tick channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [hssq_pkg::BUTTON_W-1:0]      buttons,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hssq_pkg::COIL_W-1:0]        coil_pattern,
  output logic                               moving
);

  logic                   tick;
  logic                   buf_full;
  hssq_pkg::result_t      core_result;
  hssq_pkg::result_t      out_data;
  hssq_pkg::core_status_t status;

  // A tick is accepted whenever the buffer can still absorb its result.
  assign in_stall = buf_full;
  assign tick     = in_valid && !in_stall;

  // The core advances its state on each accepted tick and presents the
  // result of that tick combinationally to the buffer.
  hssq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .buttons   (buttons),
    .result    (core_result),
    .status    (status)
  );

  hssq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (tick),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign coil_pattern = out_data.coil_pattern;
  assign moving       = out_data.moving;

  // The skid entry is in use only while the output register holds a beat.
  `ASSERT_CLK(a_skid_behind_out, clk, rst, !in_stall || out_valid, "skid full with empty output")
  // A tick that emits a step leaves a move in progress.
  `ASSERT_CLK(a_step_sets_busy, clk, rst, tick && core_result.moving |=> status.busy, "step without busy")
  // No move can start before the first tick has been seen.
  `ASSERT_CLK(a_busy_after_start, clk, rst, status.busy |-> status.started, "busy before first tick")
  // The first tick after reset never drives the coils.
  `ASSERT_CLK(a_first_tick_idle, clk, rst, tick && !status.started |-> !core_result.moving, "first tick moved")

endmodule

### hw/rtl/hssq_core.sv
// ---------------------------------------------------------------------------
// hssq_core
// Step-count registers, move state and phase index; one tick per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hssq_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hssq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hssq_pkg::STEPS_W-1:0]        cfg_data,
  input  logic                                tick,
  input  logic [hssq_pkg::BUTTON_W-1:0]       buttons,
  output hssq_pkg::result_t                   result,
  output hssq_pkg::core_status_t              status
);

  logic [hssq_pkg::STEPS_W-1:0] quarter_steps;
  logic [hssq_pkg::STEPS_W-1:0] half_steps;
  logic [hssq_pkg::STEPS_W-1:0] full_steps;

  logic                         started, started_next;
  logic                         busy, busy_next;
  logic                         reverse, reverse_next;
  hssq_pkg::move_size_t         move_size, move_size_next;
  logic [hssq_pkg::STEPS_W-1:0] steps_done, steps_done_next;
  logic [hssq_pkg::PHASE_W-1:0] phase_index, phase_index_next;
  logic [hssq_pkg::COIL_W-1:0]  held_pattern, held_pattern_next;

  logic                         one_hot;
  hssq_pkg::move_size_t         req_size;
  logic [hssq_pkg::STEPS_W-1:0] cur_limit;
  logic [hssq_pkg::STEPS_W-1:0] req_limit;
  logic                         emit;
  logic                         emit_reverse;

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_steps <= hssq_pkg::QUARTER_RESET;
      half_steps    <= hssq_pkg::HALF_RESET;
      full_steps    <= hssq_pkg::FULL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hssq_pkg::CFG_QUARTER: quarter_steps <= cfg_data;
        hssq_pkg::CFG_HALF:    half_steps    <= cfg_data;
        hssq_pkg::CFG_FULL:    full_steps    <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [hssq_pkg::STEPS_W-1:0] limit_of(
    input hssq_pkg::move_size_t sz,
    input logic [hssq_pkg::STEPS_W-1:0] q,
    input logic [hssq_pkg::STEPS_W-1:0] h,
    input logic [hssq_pkg::STEPS_W-1:0] f
  );
    logic [hssq_pkg::STEPS_W-1:0] r;
    case (sz)
      hssq_pkg::MOVE_QUARTER: r = q;
      hssq_pkg::MOVE_HALF:    r = h;
      default:                r = f;
    endcase
    return r;
  endfunction

  always_comb begin
    one_hot  = (buttons != '0) &&
               ((buttons & (buttons - hssq_pkg::BUTTON_W'(1))) == '0);
    // Forward buttons sit in the low half, backward in the high half.
    if (buttons[0] || buttons[3])      req_size = hssq_pkg::MOVE_QUARTER;
    else if (buttons[1] || buttons[4]) req_size = hssq_pkg::MOVE_HALF;
    else                               req_size = hssq_pkg::MOVE_FULL;
    cur_limit = limit_of(move_size, quarter_steps, half_steps, full_steps);
    req_limit = limit_of(req_size, quarter_steps, half_steps, full_steps);

    started_next      = started;
    busy_next         = busy;
    reverse_next      = reverse;
    move_size_next    = move_size;
    steps_done_next   = steps_done;
    phase_index_next  = phase_index;
    held_pattern_next = held_pattern;
    emit              = 1'b0;
    emit_reverse      = reverse;

    if (!started) begin
      started_next = 1'b1;
    end else if (busy) begin
      if (steps_done < cur_limit) begin
        emit = 1'b1;
      end else begin
        busy_next       = 1'b0;
        steps_done_next = '0;
      end
    end else if (one_hot && (req_limit != '0)) begin
      busy_next      = 1'b1;
      reverse_next   = |buttons[5:3];
      emit_reverse   = |buttons[5:3];
      move_size_next = req_size;
      emit           = 1'b1;
    end

    if (emit) begin
      held_pattern_next = hssq_pkg::half_step_pattern(phase_index);
      phase_index_next  = emit_reverse ? phase_index - hssq_pkg::PHASE_W'(1)
                                       : phase_index + hssq_pkg::PHASE_W'(1);
      // A new move starts counting from zero.
      steps_done_next   = (busy ? steps_done : '0) + hssq_pkg::STEPS_W'(1);
    end

    result.coil_pattern = held_pattern_next;
    result.moving       = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      busy         <= 1'b0;
      reverse      <= 1'b0;
      move_size    <= hssq_pkg::MOVE_QUARTER;
      steps_done   <= '0;
      phase_index  <= '0;
      held_pattern <= '0;
    end else if (tick) begin
      started      <= started_next;
      busy         <= busy_next;
      reverse      <= reverse_next;
      move_size    <= move_size_next;
      steps_done   <= steps_done_next;
      phase_index  <= phase_index_next;
      held_pattern <= held_pattern_next;
    end
  end

  assign status.started = started;
  assign status.busy    = busy;

endmodule

### hw/rtl/hssq_out_buf.sv
// ---------------------------------------------------------------------------
// hssq_out_buf
// Output register with one skid entry behind it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hssq_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hssq_pkg::result_t  push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output hssq_pkg::result_t  out_data
);

  logic              skid_valid;
  hssq_pkg::result_t skid_data;
  logic              take;

  assign take = out_valid && !out_stall;
  // The skid entry only fills while the output register holds a beat.
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (push && out_valid && !take) begin
      skid_data <= push_data;
    end
  end

endmodule
